FILE: design/tds_pkg.sv
// Shared constants and types for the triangle depth sorter.
`timescale 1ns / 1ps
package tds_pkg;
  localparam int MAX_TRIS   = 64;
  localparam int COORD_BITS = 16;
  localparam int FIELD_W    = 16;
  localparam int ID_W       = 16;
  localparam int KEY_W      = 32;
  localparam int IDX_W      = $clog2(MAX_TRIS);
  localparam int CNT_W      = $clog2(MAX_TRIS + 1);
  localparam int FQ_DEPTH   = 4;
  localparam int FQ_PTR_W   = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_W   = $clog2(FQ_DEPTH + 1);

  typedef struct packed {
    logic signed [FIELD_W-1:0] corner0_x;
    logic signed [FIELD_W-1:0] corner0_y;
    logic signed [FIELD_W-1:0] corner0_z;
    logic signed [FIELD_W-1:0] corner1_x;
    logic signed [FIELD_W-1:0] corner1_y;
    logic signed [FIELD_W-1:0] corner1_z;
    logic signed [FIELD_W-1:0] corner2_x;
    logic signed [FIELD_W-1:0] corner2_y;
    logic signed [FIELD_W-1:0] corner2_z;
    logic [ID_W-1:0]           tri_id;
    logic                      last_item;
  } tri_item_t;

  typedef struct packed {
    logic [ID_W-1:0]  out_id;
    logic [KEY_W-1:0] depth_key;
    logic             degenerate;
    logic             overflowed;
    logic             last_result;
  } tri_result_t;

  // Classified triangle as it travels from the front end to the sorter.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
    logic             deg;
    logic             last;
  } class_item_t;

  // One stored entry of the sorted list.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
    logic             deg;
  } entry_t;

  // Queue status seen by the front end and the sorter.
  typedef struct packed {
    logic                valid;
    logic [FQ_CNT_W-1:0] count;
  } fq_status_t;
endpackage

FILE: design/tds_if.sv
// Handshake interfaces for triangle items and sorted results.
`timescale 1ns / 1ps
interface tds_item_if;
  import tds_pkg::*;
  logic      valid;
  logic      ready;
  tri_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface tds_result_if;
  import tds_pkg::*;
  logic        valid;
  logic        ready;
  tri_result_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: design/tds_front.sv
// Front end: accepts triangles and computes depth key and collinearity.
`timescale 1ns / 1ps
module tds_front (
  input  logic                 clk,
  input  logic                 rst,
  tds_item_if.sink             items,
  input  tds_pkg::fq_status_t  fq_stat,
  output logic                 push,
  output tds_pkg::class_item_t push_data
);
  import tds_pkg::*;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int SUM_W  = SQ_W + 2;
  localparam int CMP_W  = SUM_W + KEY_W;

  logic                     s1_valid;
  logic signed [COORD_BITS-1:0] s1_x, s1_y, s1_z;
  logic signed [DIFF_W-1:0] s1_ux, s1_uy, s1_uz, s1_vx, s1_vy, s1_vz;
  logic [ID_W-1:0]          s1_id;
  logic                     s1_last;

  logic                     s2_valid;
  logic signed [PROD_W-1:0] s2_pa, s2_pb, s2_pc, s2_pd, s2_pe, s2_pf;
  logic [SQ_W-1:0]          s2_sx, s2_sy, s2_sz;
  logic [ID_W-1:0]          s2_id;
  logic                     s2_last;

  logic signed [COORD_BITS-1:0] c0x, c0y, c0z, c1x, c1y, c1z, c2x, c2y, c2z;
  logic [FQ_CNT_W+1:0]      used;
  logic [SUM_W-1:0]         sum;

  assign c0x = items.data.corner0_x[COORD_BITS-1:0];
  assign c0y = items.data.corner0_y[COORD_BITS-1:0];
  assign c0z = items.data.corner0_z[COORD_BITS-1:0];
  assign c1x = items.data.corner1_x[COORD_BITS-1:0];
  assign c1y = items.data.corner1_y[COORD_BITS-1:0];
  assign c1z = items.data.corner1_z[COORD_BITS-1:0];
  assign c2x = items.data.corner2_x[COORD_BITS-1:0];
  assign c2y = items.data.corner2_y[COORD_BITS-1:0];
  assign c2z = items.data.corner2_z[COORD_BITS-1:0];

  // Accept only when the queue can absorb everything already in flight.
  assign used = (FQ_CNT_W+2)'(fq_stat.count) + (FQ_CNT_W+2)'(s1_valid)
              + (FQ_CNT_W+2)'(s2_valid);
  assign items.ready = (used < (FQ_CNT_W+2)'(FQ_DEPTH));

  always_ff @(posedge clk) begin
    s1_x  <= c0x;
    s1_y  <= c0y;
    s1_z  <= c0z;
    s1_ux <= DIFF_W'(c1x) - DIFF_W'(c0x);
    s1_uy <= DIFF_W'(c1y) - DIFF_W'(c0y);
    s1_uz <= DIFF_W'(c1z) - DIFF_W'(c0z);
    s1_vx <= DIFF_W'(c2x) - DIFF_W'(c0x);
    s1_vy <= DIFF_W'(c2y) - DIFF_W'(c0y);
    s1_vz <= DIFF_W'(c2z) - DIFF_W'(c0z);
    s1_id   <= items.data.tri_id;
    s1_last <= items.data.last_item;

    s2_pa <= s1_uy * s1_vz;
    s2_pb <= s1_uz * s1_vy;
    s2_pc <= s1_uz * s1_vx;
    s2_pd <= s1_ux * s1_vz;
    s2_pe <= s1_ux * s1_vy;
    s2_pf <= s1_uy * s1_vx;
    s2_sx <= SQ_W'(s1_x * s1_x);
    s2_sy <= SQ_W'(s1_y * s1_y);
    s2_sz <= SQ_W'(s1_z * s1_z);
    s2_id   <= s1_id;
    s2_last <= s1_last;

    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= items.valid && items.ready;
      s2_valid <= s1_valid;
    end
  end

  assign sum = SUM_W'(s2_sx) + SUM_W'(s2_sy) + SUM_W'(s2_sz);

  always_comb begin
    push           = s2_valid;
    push_data.id   = s2_id;
    push_data.last = s2_last;
    // Zero cross product: each component's two products are equal.
    push_data.deg  = (s2_pa == s2_pb) && (s2_pc == s2_pd) && (s2_pe == s2_pf);
    if (CMP_W'(sum) > CMP_W'({KEY_W{1'b1}})) begin
      push_data.key = {KEY_W{1'b1}};
    end else begin
      push_data.key = KEY_W'(sum);
    end
  end
endmodule

FILE: design/tds_fifo.sv
// Short queue between the front end and the sorter.
`timescale 1ns / 1ps
module tds_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  tds_pkg::class_item_t push_data,
  input  logic                 pop,
  output tds_pkg::fq_status_t  stat,
  output tds_pkg::class_item_t head
);
  import tds_pkg::*;

  class_item_t         slots [FQ_DEPTH];
  logic [FQ_PTR_W-1:0] wp, rp;
  logic [FQ_CNT_W-1:0] count;

  assign stat.valid = (count != '0);
  assign stat.count = count;
  assign head       = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_data;
    end
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      count <= count + FQ_CNT_W'(push) - FQ_CNT_W'(pop);
    end
  end
endmodule

FILE: design/tds_sorter.sv
// Back end: insertion into the sorted store and batch emission.
`timescale 1ns / 1ps
module tds_sorter (
  input  logic                 clk,
  input  logic                 rst,
  input  tds_pkg::fq_status_t  fq_stat,
  input  tds_pkg::class_item_t head,
  output logic                 pop,
  tds_result_if.source         results
);
  import tds_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_PLACE = 3'd2;
  localparam logic [2:0] ST_ERD   = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  entry_t             store [MAX_TRIS];
  entry_t             rd_data;
  logic               we, re;
  logic [IDX_W-1:0]   wa, ra;
  entry_t             wd;

  logic [2:0]         state, state_next;
  logic [CNT_W-1:0]   count;
  logic               ovf;
  logic [IDX_W-1:0]   k, idx;
  entry_t             nw;
  logic               nw_last;
  logic               done, load, finish, full;
  tri_result_t        res;
  logic               res_valid;

  function automatic logic goes_before(entry_t n, entry_t e);
    logic r;
    if (n.deg) begin
      r = 1'b0;
    end else if (e.deg) begin
      r = 1'b1;
    end else begin
      r = n.key > e.key;
    end
    return r;
  endfunction

  assign full = (count == CNT_W'(MAX_TRIS));

  always_comb begin
    pop        = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    wa         = '0;
    ra         = '0;
    wd         = nw;
    done       = 1'b0;
    load       = 1'b0;
    finish     = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (fq_stat.valid) begin
          pop = 1'b1;
          if (full) begin
            if (head.last) begin
              state_next = ST_ERD;
            end
          end else if (count == '0) begin
            we = 1'b1;
            wd = '{id: head.id, key: head.key, deg: head.deg};
            done = 1'b1;
            state_next = head.last ? ST_ERD : ST_IDLE;
          end else begin
            re = 1'b1;
            ra = IDX_W'(count - 1'b1);
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        we = 1'b1;
        wa = k + 1'b1;
        if (goes_before(nw, rd_data)) begin
          wd = rd_data;
          if (k == '0) begin
            state_next = ST_PLACE;
          end else begin
            re = 1'b1;
            ra = k - 1'b1;
          end
        end else begin
          done = 1'b1;
          state_next = nw_last ? ST_ERD : ST_IDLE;
        end
      end
      ST_PLACE: begin
        we = 1'b1;
        done = 1'b1;
        state_next = nw_last ? ST_ERD : ST_IDLE;
      end
      ST_ERD: begin
        re = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!res_valid || results.ready) begin
          load = 1'b1;
          if (idx == IDX_W'(count - 1'b1)) begin
            finish = 1'b1;
            state_next = ST_IDLE;
          end else begin
            re = 1'b1;
            ra = idx + 1'b1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store[wa] <= wd;
    end
    if (re) begin
      rd_data <= store[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      nw      <= '{id: head.id, key: head.key, deg: head.deg};
      nw_last <= head.last;
      k       <= IDX_W'(count - 1'b1);
    end else if (state == ST_SCAN) begin
      k <= k - 1'b1;
    end
    if (load) begin
      res.out_id      <= rd_data.id;
      res.depth_key   <= rd_data.key;
      res.degenerate  <= rd_data.deg;
      res.overflowed  <= ovf;
      res.last_result <= finish;
    end
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      idx       <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop && full) begin
        ovf <= 1'b1;
      end
      if (finish) begin
        count <= '0;
        ovf   <= 1'b0;
        idx   <= '0;
      end else begin
        if (done) begin
          count <= count + 1'b1;
        end
        if (load) begin
          idx <= idx + 1'b1;
        end
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign results.valid = res_valid;
  assign results.data  = res;
endmodule

FILE: design/triangle_depth_sorter.sv
// Top level of the triangle depth sorter.
//
// Channel  | Direction | Payload
// ---------+-----------+--------------------------------------------------
// items    | in        | three corners, tri_id, last_item
// results  | out       | out_id, depth_key, degenerate, overflowed, last_result
//
// The front end takes one triangle per cycle while the four-entry queue has
// room, and classifies it in two pipeline stages (differences, then products).
// The sorter inserts one triangle by scanning the store from its tail, one
// entry per cycle through the store's single read port. After the closing
// item the batch is read out and emitted at one result per cycle while the
// output is not stalled. Reset is synchronous; the store needs no clearing
// since only written entries are read. Either side may stall; the queue and
// output register decouple them.
`timescale 1ns / 1ps
module triangle_depth_sorter (
  input logic          clk,
  input logic          rst,
  tds_item_if.sink     items,
  tds_result_if.source results
);
  import tds_pkg::*;

  fq_status_t  fq_stat;
  class_item_t push_data, head;
  logic        push, pop;

  // Front end: handshake on the item channel and geometric classification.
  tds_front u_front (
    .clk(clk), .rst(rst), .items(items), .fq_stat(fq_stat),
    .push(push), .push_data(push_data)
  );

  // Queue of classified triangles.
  tds_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data),
    .pop(pop), .stat(fq_stat), .head(head)
  );

  // Sorted store with insertion scan and emission.
  tds_sorter u_sorter (
    .clk(clk), .rst(rst), .fq_stat(fq_stat), .head(head),
    .pop(pop), .results(results)
  );

  // The credit check must keep the queue from ever being pushed while full.
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    push |-> (fq_stat.count < FQ_CNT_W'(FQ_DEPTH)))
    else $error("queue pushed while full");

  // The sorter never pops an empty queue.
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> fq_stat.valid)
    else $error("queue popped while empty");

  // A waiting result stays offered and unchanged until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.ready) |=> (results.valid && $stable(results.data)))
    else $error("result changed or dropped while stalled");
endmodule
